>>> rtl/qse_pkg.sv
// qse_pkg: shared constants and types for the quicksort engine
// no dependencies; used by qse_cell, quicksort_engine_unit, qse_checker and tb

package qse_pkg;

  localparam int unsigned MAX_ITEMS   = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_ITEMS + 1);

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the broadcast value in order
    logic pop;  // shift every entry one cell towards the head
  } qse_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } qse_state_e;

endpackage

>>> rtl/quicksort_engine_unit.sv
// quicksort_engine_unit: top level of the streaming sorter
// depends on qse_pkg and qse_cell
//
// Collects a set of signed values, one transaction per cycle on the slave
// side, with tlast on the final one, and returns them in ascending order on
// the master side, tlast on the last result. The values are kept in a chain
// of MAX_ITEMS insertion cells: each arriving value is compared against
// every stored entry at once and the larger entries step one cell up, so the
// chain is always sorted and loading runs at one transaction per cycle with
// no sort pass afterwards. Once the last value is in, the head cell is the
// output register and the chain shifts down by one on each result taken, so
// a set of n values gives n results at one per cycle while m_axis_tready_i
// is held high. The slave side is held off while a set is being returned and
// opens again in the cycle after the final result is taken. Values arriving
// after MAX_ITEMS are stored are dropped (including a dropped last value,
// whose tlast still closes the set) and tuser is raised on every result of
// that set.

module quicksort_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,   // last_item
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic        m_axis_tlast_o,   // final_result
  output logic        m_axis_tuser_o    // [0] overflow
);

  localparam int unsigned N  = qse_pkg::MAX_ITEMS;
  localparam int unsigned VW = qse_pkg::VALUE_WIDTH;

  qse_pkg::qse_state_e              state_q, state_d;
  logic [qse_pkg::CNT_W-1:0]        count_q, count_d;
  logic                             ovf_q, ovf_d;
  qse_pkg::qse_ctrl_t               ctrl;

  logic                             s_fire, m_fire, full;
  logic signed [VW-1:0]             x;

  logic                             cell_gt    [N];
  logic                             cell_valid [N];
  logic signed [VW-1:0]             cell_val   [N];

  // value as carried on the bus, low VALUE_WIDTH bits as a signed number
  assign x = VW'(s_axis_tdata_i);

  assign full   = (count_q == qse_pkg::CNT_W'(N));
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == qse_pkg::ST_LOAD);
  // head cell holds the smallest remaining value
  assign m_axis_tvalid_o = (state_q == qse_pkg::ST_DRAIN) && cell_valid[0];
  assign m_axis_tdata_o  = 32'(cell_val[0]);
  assign m_axis_tlast_o  = !cell_valid[1];
  assign m_axis_tuser_o  = ovf_q;

  always_comb begin
    ctrl.ins = s_fire && !full;
    ctrl.pop = m_fire;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      qse_pkg::ST_LOAD: begin
        if (s_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + qse_pkg::CNT_W'(1);
          end
          if (s_axis_tlast_i) begin
            state_d = qse_pkg::ST_DRAIN;
          end
        end
      end
      qse_pkg::ST_DRAIN: begin
        // final result taken: chain is empty, start a new set
        if (m_fire && !cell_valid[1]) begin
          state_d = qse_pkg::ST_LOAD;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = qse_pkg::ST_LOAD;
        count_d = '0;
        ovf_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qse_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // sorting chain: cell 0 is the head (smallest), neighbours pass entries
  // up on insert and down on each result taken
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                 prev_gt, prev_valid, next_valid;
    logic signed [VW-1:0] prev_val, next_val;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_valid = 1'b1;
      assign prev_val   = '0;
    end else begin : g_body
      assign prev_gt    = cell_gt[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_val   = cell_val[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_val   = '0;
    end else begin : g_link
      assign next_valid = cell_valid[i+1];
      assign next_val   = cell_val[i+1];
    end

    qse_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .x_i          (x),
      .prev_gt_i    (prev_gt),
      .prev_valid_i (prev_valid),
      .prev_val_i   (prev_val),
      .next_valid_i (next_valid),
      .next_val_i   (next_val),
      .gt_o         (cell_gt[i]),
      .valid_o      (cell_valid[i]),
      .val_o        (cell_val[i])
    );
  end

endmodule

>>> rtl/qse_cell.sv
// qse_cell: one entry of the sorting chain, holds a value and its valid bit
// depends on qse_pkg

module qse_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  qse_pkg::qse_ctrl_t                     ctrl_i,
  input  logic signed [qse_pkg::VALUE_WIDTH-1:0] x_i,
  input  logic                                   prev_gt_i,
  input  logic                                   prev_valid_i,
  input  logic signed [qse_pkg::VALUE_WIDTH-1:0] prev_val_i,
  input  logic                                   next_valid_i,
  input  logic signed [qse_pkg::VALUE_WIDTH-1:0] next_val_i,
  output logic                                   gt_o,
  output logic                                   valid_o,
  output logic signed [qse_pkg::VALUE_WIDTH-1:0] val_o
);

  logic                                   valid_q, valid_d;
  logic signed [qse_pkg::VALUE_WIDTH-1:0] val_q, val_d;

  // entry is strictly above the incoming value, so it moves one place up
  assign gt_o    = valid_q && (val_q > x_i);
  assign valid_o = valid_q;
  assign val_o   = val_q;

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      val_d   = next_val_i;
    end else if (ctrl_i.ins) begin
      if (prev_gt_i) begin
        valid_d = 1'b1;
        val_d   = prev_val_i;
      end else if (gt_o || (!valid_q && prev_valid_i)) begin
        valid_d = 1'b1;
        val_d   = x_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> verif/qse_checker.sv
// qse_checker: watches both stream channels of quicksort_engine_unit, predicts the sorted sets
// depends on qse_pkg for MAX_ITEMS and VALUE_WIDTH; instantiated beside the block by tb
`timescale 1ns / 1ps

module qse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic        s_tlast_i,   // last_item
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [31:0] sorted_value
  input  logic        m_tlast_i,   // final_result
  input  logic        m_tuser_i,   // [0] overflow
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  typedef struct {
    logic signed [qse_pkg::VALUE_WIDTH-1:0] sorted_value;
    logic                                   final_result;
    logic                                   overflow;
  } sort_result_t;

  sort_result_t                           sorted_q[$];
  logic signed [qse_pkg::VALUE_WIDTH-1:0] set_vals[qse_pkg::MAX_ITEMS];
  int                                     set_len      = 0;
  logic                                   set_overflow = 1'b0;
  int                                     mismatches   = 0;
  int                                     results_seen = 0;
  int                                     awaited      = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = awaited;
  assign results_o    = results_seen;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] qse_checker mismatch: %s", $time, msg);
    end
  endtask

  // ascending signed order of the stored part of the set, queued as expected results
  function automatic void release_sorted_set();
    logic signed [qse_pkg::VALUE_WIDTH-1:0] key;
    sort_result_t                           res;
    int                                     j;
    for (int i = 1; i < set_len; i++) begin
      key = set_vals[i];
      j   = i - 1;
      while (j >= 0 && set_vals[j] > key) begin
        set_vals[j + 1] = set_vals[j];
        j--;
      end
      set_vals[j + 1] = key;
    end
    for (int k = 0; k < set_len; k++) begin
      res.sorted_value = set_vals[k];
      res.final_result = (k == set_len - 1);
      res.overflow     = set_overflow;
      sorted_q.push_back(res);
    end
  endfunction

  // store or drop one value; tlast closes the set even when its value is dropped
  function automatic void absorb_value(input logic [31:0] value, input logic last);
    if (set_len < qse_pkg::MAX_ITEMS) begin
      set_vals[set_len] = value;
      set_len++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last) begin
      release_sorted_set();
      set_len      = 0;
      set_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    sort_result_t exp_res;
    if (rst_ni) begin
      // results first: a set's results can only follow its last transaction
      if (m_tvalid_i && m_tready_i) begin
        results_seen++;
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", $signed(m_tdata_i)));
        end else begin
          exp_res = sorted_q.pop_front();
          if (m_tdata_i !== exp_res.sorted_value) begin
            report_mismatch($sformatf("sorted_value got %0d exp %0d",
                                      $signed(m_tdata_i), exp_res.sorted_value));
          end
          if (m_tlast_i !== exp_res.final_result) begin
            report_mismatch($sformatf("final_result got %b exp %b",
                                      m_tlast_i, exp_res.final_result));
          end
          if (m_tuser_i !== exp_res.overflow) begin
            report_mismatch($sformatf("overflow got %b exp %b", m_tuser_i, exp_res.overflow));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_value(s_tdata_i, s_tlast_i);
      end
      awaited = sorted_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// tb: stimulus and verdict for quicksort_engine_unit
// depends on qse_pkg, quicksort_engine_unit and qse_checker
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS   = 196;
  localparam int CALM_ITEMS     = 40;    // tail of the run with no idling on either side
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off while a set waits to be returned
  localparam int HOLD_AFTER     = 40;    // results taken before the hold-off starts
  localparam int DRAIN_CYCLES   = 4 * qse_pkg::MAX_ITEMS;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  int fail_count;
  int pending_cnt;
  int results_cnt;

  bit calm          = 1'b0;
  int items_sent    = 0;
  int sets_sent     = 0;
  int overflow_sets = 0;
  int idle_cycles   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quicksort_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [31:0] value
    .s_axis_tlast_i  (s_tlast),   // last_item
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [31:0] sorted_value
    .m_axis_tlast_o  (m_tlast),   // final_result
    .m_axis_tuser_o  (m_tuser)    // [0] overflow
  );

  qse_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_cnt),
    .results_o    (results_cnt)
  );

  // one slave-side transaction; tready is looked at on the falling edge, once settled
  task automatic send_item(input logic [31:0] value, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
    items_sent++;
  endtask

  // mix of full-range values, a narrow band around zero for duplicates, and the extremes
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 16) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // order 0 random, 1 ascending run, 2 descending run
  task automatic send_random_set(input int n, input int order);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      case (order)
        1:       send_item(base + i, i == n - 1);
        2:       send_item(base - i, i == n - 1);
        default: send_item(pick_value(), i == n - 1);
      endcase
    end
    sets_sent++;
    if (n > qse_pkg::MAX_ITEMS) overflow_sets++;
  endtask

  // stimulus: reset, a handful of directed sets, then random sets
  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a lone element, the most positive value
    send_item(32'h7FFF_FFFF, 1'b1);
    sets_sent++;

    // both extremes, zero, minus one and a repeated value
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    sets_sent++;

    // too many elements, descending, with the marked last one among those dropped
    for (int i = 0; i < qse_pkg::MAX_ITEMS + 2; i++) begin
      send_item(32'(8 - i), i == qse_pkg::MAX_ITEMS + 1);
    end
    sets_sent++;
    overflow_sets++;

    while (items_sent < 24 + RANDOM_ITEMS) begin
      if (items_sent >= 24 + RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 7))
        0:       n = $urandom_range(qse_pkg::MAX_ITEMS + 1, qse_pkg::MAX_ITEMS + 6);
        1:       n = qse_pkg::MAX_ITEMS;
        2:       n = 1;
        default: n = $urandom_range(2, qse_pkg::MAX_ITEMS - 1);
      endcase
      send_random_set(n, $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 2));
    end
    s_tvalid <= 1'b0;

    // let the last set drain, then keep watching to catch stray results
    @(negedge clk_i);
    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d sets (%0d with dropped elements), %0d values in, %0d results out",
             sets_sent, overflow_sets, items_sent, results_cnt);
    if (fail_count == 0) begin
      $display("** quicksort_engine_unit: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** quicksort_engine_unit: FAILED **");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off while the sender keeps offering
  initial begin
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(negedge clk_i); while (!m_tvalid);
      @(posedge clk_i);
      taken++;
    end
  end

  // watchdog: too long with no transaction on either side ends the run
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** quicksort_engine_unit: FAILED **");
      $finish;
    end
  end

endmodule
